// ===== rtl/mlsu_pkg.sv =====
// Shared types and constants for the load/store unit.
package mlsu_pkg;

  localparam int WORD_W = 32;
  localparam int OFFSET_W = 16;
  localparam int KIND_W = 4;
  localparam int LANES = WORD_W / 8;

  // Instruction kinds; codes above KIND_SWR are unused
  typedef enum logic [KIND_W-1:0] {
    KIND_LB  = 4'd0,
    KIND_LBU = 4'd1,
    KIND_LH  = 4'd2,
    KIND_LHU = 4'd3,
    KIND_LW  = 4'd4,
    KIND_LWL = 4'd5,
    KIND_LWR = 4'd6,
    KIND_SB  = 4'd7,
    KIND_SH  = 4'd8,
    KIND_SW  = 4'd9,
    KIND_SWL = 4'd10,
    KIND_SWR = 4'd11
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [WORD_W-1:0]          base_value;
    logic signed [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]          target_value;
    logic [WORD_W-1:0]          memory_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] effective_address;
    logic              register_write;
    logic [WORD_W-1:0] register_result;
    logic              memory_write;
    logic [WORD_W-1:0] store_lanes;
    logic [LANES-1:0]  byte_enables;
  } rsp_t;

endpackage

// ===== rtl/mlsu_if.sv =====
// Valid/ready channels for instruction items and result items.
interface mlsu_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [mlsu_pkg::KIND_W-1:0]          kind;
  logic [mlsu_pkg::WORD_W-1:0]          base_value;
  logic signed [mlsu_pkg::OFFSET_W-1:0] offset;
  logic [mlsu_pkg::WORD_W-1:0]          target_value;
  logic [mlsu_pkg::WORD_W-1:0]          memory_word;

  modport source (output valid, kind, base_value, offset, target_value, memory_word,
                  input ready);
  modport sink (input valid, kind, base_value, offset, target_value, memory_word,
                output ready);
endinterface

interface mlsu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mlsu_pkg::WORD_W-1:0] effective_address;
  logic                        register_write;
  logic [mlsu_pkg::WORD_W-1:0] register_result;
  logic                        memory_write;
  logic [mlsu_pkg::WORD_W-1:0] store_lanes;
  logic [mlsu_pkg::LANES-1:0]  byte_enables;

  modport source (output valid, effective_address, register_write, register_result,
                  memory_write, store_lanes, byte_enables, input ready);
  modport sink (input valid, effective_address, register_write, register_result,
                memory_write, store_lanes, byte_enables, output ready);
endinterface

// ===== rtl/mlsu_datapath.sv =====
// Address add, load extract/merge and store lane placement for one item.
module mlsu_datapath (
  input  mlsu_pkg::req_t req,
  output mlsu_pkg::rsp_t rsp
);
  import mlsu_pkg::*;

  logic [WORD_W-1:0] ea;
  logic [1:0]        byte_sel;
  logic [4:0]        byte_shift;
  logic [4:0]        left_shift;
  logic [4:0]        half_shift;
  logic [WORD_W-1:0] mem_byte_dn;
  logic [WORD_W-1:0] mem_half_dn;
  logic [WORD_W-1:0] lwl_mask;
  logic [WORD_W-1:0] lwr_mask;

  // Form address and shift amounts
  assign ea          = req.base_value + {{(WORD_W-OFFSET_W){req.offset[OFFSET_W-1]}},
                                         req.offset};
  assign byte_sel    = ea[1:0];
  assign byte_shift  = {byte_sel, 3'b000};
  assign left_shift  = {~byte_sel, 3'b000};
  assign half_shift  = {ea[1], 4'b0000};
  assign mem_byte_dn = req.memory_word >> byte_shift;
  assign mem_half_dn = req.memory_word >> half_shift;
  assign lwl_mask    = {WORD_W{1'b1}} << left_shift;
  assign lwr_mask    = {WORD_W{1'b1}} >> byte_shift;

  // Decode kind and build the result
  always_comb begin
    rsp = '0;
    rsp.effective_address = ea;
    unique case (kind_t'(req.kind))
      KIND_LB: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = {{24{mem_byte_dn[7]}}, mem_byte_dn[7:0]};
      end
      KIND_LBU: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = {24'b0, mem_byte_dn[7:0]};
      end
      KIND_LH: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = {{16{mem_half_dn[15]}}, mem_half_dn[15:0]};
      end
      KIND_LHU: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = {16'b0, mem_half_dn[15:0]};
      end
      KIND_LW: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = req.memory_word;
      end
      KIND_LWL: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = (req.target_value & ~lwl_mask) |
                              (req.memory_word << left_shift);
      end
      KIND_LWR: begin
        rsp.register_write  = 1'b1;
        rsp.register_result = (req.target_value & ~lwr_mask) | mem_byte_dn;
      end
      KIND_SB: begin
        rsp.memory_write = 1'b1;
        rsp.store_lanes  = {24'b0, req.target_value[7:0]} << byte_shift;
        rsp.byte_enables = 4'b0001 << byte_sel;
      end
      KIND_SH: begin
        rsp.memory_write = 1'b1;
        rsp.store_lanes  = {16'b0, req.target_value[15:0]} << half_shift;
        rsp.byte_enables = ea[1] ? 4'b1100 : 4'b0011;
      end
      KIND_SW: begin
        rsp.memory_write = 1'b1;
        rsp.store_lanes  = req.target_value;
        rsp.byte_enables = 4'b1111;
      end
      KIND_SWL: begin
        rsp.memory_write = 1'b1;
        rsp.store_lanes  = req.target_value >> left_shift;
        rsp.byte_enables = 4'((5'd2 << byte_sel) - 5'd1);
      end
      KIND_SWR: begin
        rsp.memory_write = 1'b1;
        rsp.store_lanes  = req.target_value << byte_shift;
        rsp.byte_enables = 4'(5'h0F << byte_sel);
      end
      default: begin
        rsp.register_write = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mips_load_store_unit.sv =====
// Top level of the load/store unit: input register, datapath, result register.
// Each item passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle while results are taken; the input register and the result register
// each hold one item, and the datapath between them is a single add and shift.
// A stalled result holds the result register; the input register refills behind it.
// Reset (rst, synchronous) empties both registers; the data they hold is not reset.
module mips_load_store_unit (
  input logic       clk,
  input logic       rst,
  mlsu_req_if.sink   item,
  mlsu_rsp_if.source result
);
  import mlsu_pkg::*;

  logic stage_valid;
  req_t stage;
  logic out_valid;
  rsp_t out_data;
  rsp_t comp;
  logic out_free;
  logic item_xfer;

  assign out_free   = !out_valid || result.ready;
  assign item.ready = !stage_valid || out_free;
  assign item_xfer  = item.valid && item.ready;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
    if (item_xfer) begin
      stage.kind         <= item.kind;
      stage.base_value   <= item.base_value;
      stage.offset       <= item.offset;
      stage.target_value <= item.target_value;
      stage.memory_word  <= item.memory_word;
    end
  end

  mlsu_datapath u_datapath (
    .req (stage),
    .rsp (comp)
  );

  // Advance into the result register when it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
    if (out_free && stage_valid) begin
      out_data <= comp;
    end
  end

  assign result.valid             = out_valid;
  assign result.effective_address = out_data.effective_address;
  assign result.register_write    = out_data.register_write;
  assign result.register_result   = out_data.register_result;
  assign result.memory_write      = out_data.memory_write;
  assign result.store_lanes       = out_data.store_lanes;
  assign result.byte_enables      = out_data.byte_enables;

  // Load and store never both
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.register_write && out_data.memory_write))
    else $error("result both loads and stores");

  // A load drives no lanes; a store gives no register value
  a_load_no_lanes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.register_write) |-> (out_data.byte_enables == '0 &&
                                                out_data.store_lanes == '0))
    else $error("load with store lanes");

  // A store enables at least one lane and gives no register value
  a_store_lanes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.memory_write) |-> (out_data.byte_enables != '0 &&
                                              out_data.register_result == '0))
    else $error("store without enabled lanes");

  // An item held in the input register reaches the result register once it is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_free) |=> out_valid)
    else $error("held item did not advance");

  // Reset leaves both registers empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !stage_valid))
    else $error("registers not empty after reset");

endmodule
